FILE: rtl/xymodem_packet_checker_macros.svh
// Assertion macros for the packet checker
`ifndef XYMODEM_PACKET_CHECKER_MACROS_SVH
`define XYMODEM_PACKET_CHECKER_MACROS_SVH

// same-cycle implication, idle during reset
`define XPC_AST_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, idle during reset
`define XPC_AST_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/xpc_pkg.sv
// Package: types, codes and CRC function for the packet checker
`timescale 1ns / 1ps
package xpc_pkg;

    localparam int unsigned POS_W = 11;
    localparam logic [POS_W-1:0] POS_MAX = 11'd2047;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] START_SHORT = 8'h01;
    localparam logic [7:0] START_LONG  = 8'h02;
    localparam logic [7:0] NUM_SUM_OK  = 8'hff;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_LEN   = 2'd1;
    localparam logic [1:0] ST_BAD_NUM   = 2'd2;
    localparam logic [1:0] ST_BAD_CHECK = 2'd3;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic MODE_SUM = 1'b0;
    localparam logic MODE_CRC = 1'b1;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_packet;
    } t_in_req;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] payload_byte;
        logic [1:0] status_code;
        logic [7:0] block_number;
        logic       run_last;
    } t_out_res;

    // byte-wide CRC-16 update, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/xpc_in_if.sv
// Input channel interface: received byte requests
`timescale 1ns / 1ps
interface xpc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_packet;

    modport source (output valid, output rx_byte, output end_of_packet, input ready);
    modport sink   (input valid, input rx_byte, input end_of_packet, output ready);
endinterface

FILE: rtl/xpc_out_if.sv
// Output channel interface: payload bytes and packet status
`timescale 1ns / 1ps
interface xpc_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [1:0] status_code;
    logic [7:0] block_number;
    logic       run_last;

    modport source (output valid, output result_kind, output payload_byte,
                    output status_code, output block_number, output run_last,
                    input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input status_code, input block_number, input run_last,
                    output ready);
endinterface

FILE: rtl/xpc_in_stage.sv
// Input register stage for received byte requests
`timescale 1ns / 1ps
module xpc_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  xpc_pkg::t_in_req i_req,
    output logic             o_ready,
    input  logic             i_take,
    output logic             o_valid,
    output xpc_pkg::t_in_req o_req
);
    import xpc_pkg::*;

    logic    r_valid;
    t_in_req r_req;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req <= i_req;
        end
    end
endmodule

FILE: rtl/xpc_core.sv
// Packet state, check logic and result register
`timescale 1ns / 1ps
module xpc_core #(
    parameter logic [10:0] SHORT_LEN = 11'd128,
    parameter logic [10:0] LONG_LEN  = 11'd1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_s1_valid,
    input  xpc_pkg::t_in_req  i_s1,
    output logic              o_take,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output xpc_pkg::t_out_res o_res
);
    import xpc_pkg::*;

    logic             r_mode;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] r_len;
    logic [7:0]       r_num;
    logic [7:0]       r_cpl;
    logic [15:0]      r_crc;
    logic [7:0]       r_sum;
    logic [15:0]      r_chk;
    logic             r_out_valid;
    t_out_res         r_res;

    logic [POS_W-1:0] n_pos;
    logic [POS_W-1:0] n_len;
    logic [7:0]       n_num;
    logic [7:0]       n_cpl;
    logic [15:0]      n_crc;
    logic [7:0]       n_sum;
    logic [15:0]      n_chk;
    logic             n_emit;
    t_out_res         n_res;

    logic             out_free;
    logic             is_payload;
    logic [POS_W:0]   expected;
    logic [7:0]       num_sum;
    logic             check_bad;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_take      = i_s1_valid && out_free;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_res;

    always_comb begin
        n_pos      = r_pos;
        n_len      = r_len;
        n_num      = r_num;
        n_cpl      = r_cpl;
        n_crc      = r_crc;
        n_sum      = r_sum;
        n_chk      = r_chk;
        is_payload = 1'b0;

        if (r_pos == '0) begin
            case (i_s1.rx_byte)
                START_SHORT: n_len = SHORT_LEN;
                START_LONG:  n_len = LONG_LEN;
                default:     n_len = '0;
            endcase
        end else if (r_pos == 11'd1) begin
            n_num = i_s1.rx_byte;
        end else if (r_pos == 11'd2) begin
            n_cpl = i_s1.rx_byte;
        end else if ({1'b0, r_pos} < 12'd3 + {1'b0, r_len}) begin
            n_crc      = crc_byte(r_crc, i_s1.rx_byte);
            n_sum      = r_sum + i_s1.rx_byte;
            is_payload = (r_len != '0);
        end else begin
            n_chk = {r_chk[7:0], i_s1.rx_byte};
        end

        if (r_pos < POS_MAX) begin
            n_pos = r_pos + 11'd1;
        end

        expected  = 12'd3 + {1'b0, n_len} + ((r_mode == MODE_CRC) ? 12'd2 : 12'd1);
        num_sum   = n_num + n_cpl;
        check_bad = (r_mode == MODE_CRC) ? (n_chk != n_crc) : (n_chk[7:0] != n_sum);

        n_res  = '0;
        n_emit = 1'b0;
        if (i_s1.end_of_packet) begin
            n_emit             = 1'b1;
            n_res.result_kind  = KIND_STATUS;
            n_res.block_number = n_num;
            n_res.run_last     = 1'b1;
            if (n_len == '0 || r_pos >= POS_MAX || ({1'b0, r_pos} + 12'd1) != expected) begin
                n_res.status_code = ST_BAD_LEN;
            end else if (num_sum != NUM_SUM_OK) begin
                n_res.status_code = ST_BAD_NUM;
            end else if (check_bad) begin
                n_res.status_code = ST_BAD_CHECK;
            end else begin
                n_res.status_code = ST_OK;
            end
        end else if (is_payload) begin
            n_emit             = 1'b1;
            n_res.result_kind  = KIND_PAYLOAD;
            n_res.payload_byte = i_s1.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CRC;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_len <= '0;
            r_num <= '0;
            r_cpl <= '0;
            r_crc <= '0;
            r_sum <= '0;
            r_chk <= '0;
        end else if (o_take) begin
            if (i_s1.end_of_packet) begin
                r_pos <= '0;
                r_len <= '0;
                r_num <= '0;
                r_cpl <= '0;
                r_crc <= '0;
                r_sum <= '0;
                r_chk <= '0;
            end else begin
                r_pos <= n_pos;
                r_len <= n_len;
                r_num <= n_num;
                r_cpl <= n_cpl;
                r_crc <= n_crc;
                r_sum <= n_sum;
                r_chk <= n_chk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= o_take && n_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && n_emit) begin
            r_res <= n_res;
        end
    end
endmodule

FILE: rtl/xymodem_packet_checker.sv
// Top level: XMODEM/YMODEM receive packet checker
// A byte request is first held in the input register; its result then goes to the result register.
// Throughput: one byte per cycle unless the output stalls; the input and result registers
// each hand on one item per cycle, and the CRC update is one unrolled byte step.
// Reset (i_rst_n low, synchronous): packet state and both stages clear,
// check mode returns to CRC-16.
`timescale 1ns / 1ps
module xymodem_packet_checker #(
    parameter int unsigned SHORT_BLOCK = 128,
    parameter int unsigned LONG_BLOCK  = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    xpc_in_if.sink    i_in,
    xpc_out_if.source o_out
);
    import xpc_pkg::*;

    localparam logic [POS_W-1:0] SHORT_LEN = POS_W'(SHORT_BLOCK);
    localparam logic [POS_W-1:0] LONG_LEN  = POS_W'(LONG_BLOCK);

    t_in_req  in_req;
    t_in_req  s1_req;
    logic     s1_valid;
    logic     take;
    t_out_res res;

    assign in_req.rx_byte       = i_in.rx_byte;
    assign in_req.end_of_packet = i_in.end_of_packet;

    xpc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .i_req   (in_req),
        .o_ready (i_in.ready),
        .i_take  (take),
        .o_valid (s1_valid),
        .o_req   (s1_req)
    );

    xpc_core #(
        .SHORT_LEN (SHORT_LEN),
        .LONG_LEN  (LONG_LEN)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s1_valid  (s1_valid),
        .i_s1        (s1_req),
        .o_take      (take),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_res       (res)
    );

    assign o_out.result_kind  = res.result_kind;
    assign o_out.payload_byte = res.payload_byte;
    assign o_out.status_code  = res.status_code;
    assign o_out.block_number = res.block_number;
    assign o_out.run_last     = res.run_last;
endmodule

FILE: rtl/xpc_checker.sv
// Port-level assertion checker for the packet checker, with its bind
`timescale 1ns / 1ps
`include "xymodem_packet_checker_macros.svh"
module xpc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_result_kind,
    input logic [7:0] i_payload_byte,
    input logic [1:0] i_status_code,
    input logic [7:0] i_block_number,
    input logic       i_run_last
);
    import xpc_pkg::*;

    `XPC_AST_NOW(a_last_is_status, i_clk, i_rst_n, i_out_valid, (i_run_last == (i_result_kind == KIND_STATUS)), "run_last does not match result kind")
    `XPC_AST_NOW(a_payload_clean, i_clk, i_rst_n, i_out_valid && (i_result_kind == KIND_PAYLOAD), (i_status_code == ST_OK) && (i_block_number == 8'h00), "payload request carries status fields")
    `XPC_AST_NOW(a_status_clean, i_clk, i_rst_n, i_out_valid && (i_result_kind == KIND_STATUS), (i_payload_byte == 8'h00), "status request carries payload byte")
    `XPC_AST_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_status_code) && $stable(i_payload_byte), "stalled result request changed")
endmodule

bind xymodem_packet_checker xpc_checker u_xpc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_result_kind  (o_out.result_kind),
    .i_payload_byte (o_out.payload_byte),
    .i_status_code  (o_out.status_code),
    .i_block_number (o_out.block_number),
    .i_run_last     (o_out.run_last)
);
